@@ rtl/ftr_pkg.sv @@
package ftr_pkg;

   localparam int MAX_LEN_DEF = 255;
   localparam int LEN_W       = 8;

   typedef enum logic [10:0] {
      PH_IDLE     = 11'b000_0000_0001,
      PH_START    = 11'b000_0000_0010,
      PH_MINUS    = 11'b000_0000_0100,
      PH_LEADPT   = 11'b000_0000_1000,
      PH_INT      = 11'b000_0001_0000,
      PH_FRAC     = 11'b000_0010_0000,
      PH_EXP_E    = 11'b000_0100_0000,
      PH_EXP_SIGN = 11'b000_1000_0000,
      PH_EXP_DIG  = 11'b001_0000_0000,
      PH_NAN_N    = 11'b010_0000_0000,
      PH_NAN_A    = 11'b100_0000_0000
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_SHORT  = 2'd1,
      ST_BAD    = 2'd2,
      ST_LONEPT = 2'd3
   } status_type;

   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_POINT = 8'h2E;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_E     = 8'h65;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;
   localparam logic [7:0] CASE_OFS = 8'h20;

   typedef struct packed {
      logic [7:0] ch;
      logic       start_req;
      logic       at_end;
   } item_type;

   typedef struct packed {
      logic             valid;
      status_type       status;
      logic [LEN_W-1:0] length;
   } result_type;

   function automatic logic is_dig(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return ((c >= CH_UP_A) && (c <= CH_UP_Z)) ? c + CASE_OFS : c;
   endfunction

endpackage

@@ rtl/ftr_core.sv @@
module ftr_core
   import ftr_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  item_type   item,
   output result_type res
);

   localparam logic [LEN_W-1:0] LEN_CAP = (MAX_LEN < 255) ? LEN_W'(MAX_LEN) : LEN_W'(255);

   phase_type        phase_ff, phase_in;
   logic [LEN_W-1:0] consumed_ff, consumed_in;

   phase_type        ph;
   logic [LEN_W-1:0] cnt;
   logic [LEN_W-1:0] cnt_inc;
   logic [7:0]       lc;
   logic             dig;

   assign lc      = to_lower(item.ch);
   assign dig     = is_dig(item.ch);

   always_comb begin
      ph  = item.start_req ? PH_START : phase_ff;
      cnt = item.start_req ? '0 : consumed_ff;
      cnt_inc = (cnt < LEN_CAP) ? cnt + 1'b1 : cnt;

      phase_in    = phase_ff;
      consumed_in = consumed_ff;
      res.valid   = 1'b0;
      res.status  = ST_OK;
      res.length  = cnt;

      if (step_en) begin
         phase_in    = ph;
         consumed_in = cnt;
         if (ph == PH_IDLE) begin
            phase_in = PH_IDLE;
         end else if (item.at_end) begin
            res.valid  = 1'b1;
            res.status = (ph == PH_INT || ph == PH_FRAC || ph == PH_EXP_DIG) ? ST_OK : ST_SHORT;
            phase_in   = PH_IDLE;
         end else begin
            // default: advance and count the byte; finishing arms override
            consumed_in = cnt_inc;
            unique case (ph)
               PH_START, PH_MINUS: begin
                  if (item.ch == CH_MINUS && ph == PH_START) phase_in = PH_MINUS;
                  else if (item.ch == CH_POINT)             phase_in = PH_LEADPT;
                  else if (dig)                             phase_in = PH_INT;
                  else if (lc == CH_N)                      phase_in = PH_NAN_N;
                  else begin
                     res.valid = 1'b1; res.status = ST_BAD;
                  end
               end
               PH_LEADPT: begin
                  if (dig) phase_in = PH_FRAC;
                  else begin
                     res.valid = 1'b1; res.status = ST_LONEPT;
                  end
               end
               PH_INT: begin
                  if (dig)                   phase_in = PH_INT;
                  else if (item.ch == CH_POINT) phase_in = PH_FRAC;
                  else if (lc == CH_E)       phase_in = PH_EXP_E;
                  else begin
                     res.valid = 1'b1; res.status = ST_OK;
                  end
               end
               PH_FRAC: begin
                  if (dig)             phase_in = PH_FRAC;
                  else if (lc == CH_E) phase_in = PH_EXP_E;
                  else begin
                     res.valid = 1'b1; res.status = ST_OK;
                  end
               end
               PH_EXP_E: begin
                  if (item.ch == CH_PLUS || item.ch == CH_MINUS) phase_in = PH_EXP_SIGN;
                  else if (dig)                                phase_in = PH_EXP_DIG;
                  else begin
                     res.valid = 1'b1; res.status = ST_BAD;
                  end
               end
               PH_EXP_SIGN: begin
                  if (dig) phase_in = PH_EXP_DIG;
                  else begin
                     res.valid = 1'b1; res.status = ST_BAD;
                  end
               end
               PH_EXP_DIG: begin
                  if (dig) phase_in = PH_EXP_DIG;
                  else begin
                     res.valid = 1'b1; res.status = ST_OK;
                  end
               end
               PH_NAN_N: begin
                  if (lc == CH_A) phase_in = PH_NAN_A;
                  else begin
                     res.valid = 1'b1; res.status = ST_BAD;
                  end
               end
               PH_NAN_A: begin
                  // final n of nan is counted and closes the field
                  res.valid = 1'b1;
                  if (lc == CH_N) begin
                     res.status = ST_OK;
                     res.length = cnt_inc;
                  end else begin
                     res.status = ST_BAD;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
            if (res.valid) begin
               phase_in    = PH_IDLE;
               consumed_in = res.length;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         consumed_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         consumed_ff <= consumed_in;
      end
   end

endmodule

@@ rtl/float_text_recognizer.sv @@
// a word that closes the field passes the input register, and its result word is then registered for the output
// throughput: one word per cycle while the result side does not stall, as ftr_core updates the phase once per word
// a full result register that rsp_tready does not take stalls the input register, which stalls req_tready
// reset: synchronous, clears both valids, phase goes idle and the byte count to zero
module float_text_recognizer
   import ftr_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic [1:0]  req_tuser,   // [0] start_req, [1] at_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [1:0] status, [9:2] length, [15:10] zero
);

   localparam logic [LEN_W-1:0] LEN_CAP = (MAX_LEN < 255) ? LEN_W'(MAX_LEN) : LEN_W'(255);

   logic       in_valid_ff;
   item_type   in_item_ff;
   logic       rsp_valid_ff;
   status_type rsp_status_ff;
   logic [LEN_W-1:0] rsp_length_ff;

   logic       advance;
   logic       step_en;
   result_type res;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign step_en    = in_valid_ff && advance;

   ftr_core #(.MAX_LEN(MAX_LEN)) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (in_item_ff),
      .res     (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= step_en && res.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.ch        <= req_tdata;
         in_item_ff.start_req <= req_tuser[0];
         in_item_ff.at_end    <= req_tuser[1];
      end
      if (step_en && res.valid) begin
         rsp_status_ff <= res.status;
         rsp_length_ff <= res.length;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_length_ff, rsp_status_ff};

   // no word in the input register means no new result
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (advance && !in_valid_ff) |=> !rsp_tvalid)
      else $error("result without an input word");

   // a stalled input word is never dropped
   a_hold_in: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("stalled input word lost");

   a_len_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_length_ff <= LEN_CAP))
      else $error("length above cap");

   // the lone point itself is always counted
   a_lonept_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_status_ff == ST_LONEPT) |-> (rsp_length_ff != '0))
      else $error("lone point status with zero length");

endmodule

@@ dv/float_text_recognizer_tb.sv @@
`timescale 1ns / 1ps

module float_text_recognizer_tb;
   import ftr_pkg::*;

   localparam int LEN_CAP     = (MAX_LEN_DEF < 255) ? MAX_LEN_DEF : 255;
   localparam int STALL_LIMIT = 2000;
   localparam int RAND_WORDS  = 750;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      status_type st;
      logic [7:0] len;
   } field_result_type;

   // one directed word; fixed rows carry their result typed in
   typedef struct packed {
      logic [7:0] ch;
      logic       opens;
      logic       ends;
      logic       fixed;
      logic       rsp_due;
      status_type st;
      logic [7:0] len;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;  // [7:0] ch
   logic [1:0]  req_tuser = 2'b00;  // [0] start_req, [1] at_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // [1:0] status, [9:2] length, [15:10] zero

   float_text_recognizer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   phase_type        lex_phase = PH_IDLE;
   logic [7:0]       lex_count = 8'd0;
   field_result_type pending_results [$];
   item_type         field_words [$];
   int               fail_count = 0;
   int               stall_cycles = 0;
   int               live_words = 0;
   bit               send_burst = 0;
   bit               long_done = 0;

   dir_row_type dir_rows [26] = '{
      '{8'h00,    1'b0, 1'b0, 1'b1, 1'b0, ST_OK,     8'd0},  // idle, ignored
      '{"x",      1'b1, 1'b1, 1'b1, 1'b1, ST_SHORT,  8'd0},  // empty field
      '{"z",      1'b1, 1'b0, 1'b1, 1'b1, ST_BAD,    8'd0},
      '{CH_MINUS, 1'b1, 1'b0, 1'b0, 1'b0, ST_OK,     8'd0},
      '{CH_POINT, 1'b0, 1'b0, 1'b0, 1'b0, ST_OK,     8'd0},
      '{"q",      1'b0, 1'b0, 1'b1, 1'b1, ST_LONEPT, 8'd2},  // bad after lone point
      '{"0",      1'b1, 1'b0, 1'b0, 1'b0, ST_OK,     8'd0},
      '{CH_POINT, 1'b0, 1'b0, 1'b0, 1'b0, ST_OK,     8'd0},
      '{"5",      1'b0, 1'b0, 1'b0, 1'b0, ST_OK,     8'd0},
      '{"E",      1'b0, 1'b0, 1'b0, 1'b0, ST_OK,     8'd0},
      '{CH_MINUS, 1'b0, 1'b0, 1'b0, 1'b0, ST_OK,     8'd0},
      '{"3",      1'b0, 1'b0, 1'b0, 1'b0, ST_OK,     8'd0},
      '{" ",      1'b0, 1'b0, 1'b0, 1'b0, ST_OK,     8'd0},
      '{"N",      1'b1, 1'b0, 1'b0, 1'b0, ST_OK,     8'd0},
      '{"a",      1'b0, 1'b0, 1'b0, 1'b0, ST_OK,     8'd0},
      '{"N",      1'b0, 1'b0, 1'b0, 1'b0, ST_OK,     8'd0},  // nan closes on last n
      '{"1",      1'b1, 1'b0, 1'b0, 1'b0, ST_OK,     8'd0},
      '{"2",      1'b1, 1'b0, 1'b0, 1'b0, ST_OK,     8'd0},  // restart drops old field
      '{" ",      1'b0, 1'b0, 1'b0, 1'b0, ST_OK,     8'd0},
      '{CH_POINT, 1'b1, 1'b0, 1'b0, 1'b0, ST_OK,     8'd0},
      '{8'hFF,    1'b0, 1'b1, 1'b1, 1'b1, ST_SHORT,  8'd1},  // end mark after lone point
      '{"1",      1'b1, 1'b0, 1'b0, 1'b0, ST_OK,     8'd0},
      '{"e",      1'b0, 1'b0, 1'b0, 1'b0, ST_OK,     8'd0},
      '{CH_PLUS,  1'b0, 1'b0, 1'b0, 1'b0, ST_OK,     8'd0},
      '{8'hFF,    1'b0, 1'b0, 1'b0, 1'b0, ST_OK,     8'd0},
      '{8'hFF,    1'b1, 1'b0, 1'b1, 1'b1, ST_BAD,    8'd0}
   };

   function automatic bit char_is_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic logic [7:0] fold_upper(input logic [7:0] c);
      if (c >= CH_UP_A && c <= CH_UP_Z) begin
         return c + CASE_OFS;
      end
      return c;
   endfunction

   // advances the recognizer copy by one word; returns 1 when the field closes
   function automatic bit lex_word(input item_type w, output field_result_type r);
      phase_type  nx;
      bit         done;
      logic [7:0] c;
      c = w.ch;
      nx = lex_phase;
      done = 0;
      r = '{ST_OK, 8'd0};
      if (w.start_req) begin
         lex_phase = PH_START;
         lex_count = 8'd0;
      end
      if (lex_phase == PH_IDLE) begin
         return 0;
      end
      if (w.at_end) begin
         r.st = (lex_phase inside {PH_INT, PH_FRAC, PH_EXP_DIG}) ? ST_OK : ST_SHORT;
         done = 1;
      end else begin
         case (lex_phase)
            PH_START, PH_MINUS: begin
               if (c == CH_MINUS && lex_phase == PH_START) nx = PH_MINUS;
               else if (c == CH_POINT) nx = PH_LEADPT;
               else if (char_is_digit(c)) nx = PH_INT;
               else if (fold_upper(c) == CH_N) nx = PH_NAN_N;
               else begin r.st = ST_BAD; done = 1; end
            end
            PH_LEADPT: begin
               if (char_is_digit(c)) nx = PH_FRAC;
               else begin r.st = ST_LONEPT; done = 1; end
            end
            PH_INT: begin
               if (char_is_digit(c)) nx = PH_INT;
               else if (c == CH_POINT) nx = PH_FRAC;
               else if (fold_upper(c) == CH_E) nx = PH_EXP_E;
               else begin r.st = ST_OK; done = 1; end
            end
            PH_FRAC: begin
               if (char_is_digit(c)) nx = PH_FRAC;
               else if (fold_upper(c) == CH_E) nx = PH_EXP_E;
               else begin r.st = ST_OK; done = 1; end
            end
            PH_EXP_E: begin
               if (c == CH_PLUS || c == CH_MINUS) nx = PH_EXP_SIGN;
               else if (char_is_digit(c)) nx = PH_EXP_DIG;
               else begin r.st = ST_BAD; done = 1; end
            end
            PH_EXP_SIGN: begin
               if (char_is_digit(c)) nx = PH_EXP_DIG;
               else begin r.st = ST_BAD; done = 1; end
            end
            PH_EXP_DIG: begin
               if (char_is_digit(c)) nx = PH_EXP_DIG;
               else begin r.st = ST_OK; done = 1; end
            end
            PH_NAN_N: begin
               if (fold_upper(c) == CH_A) nx = PH_NAN_A;
               else begin r.st = ST_BAD; done = 1; end
            end
            default: begin
               // final n of nan is counted and closes the field
               if (fold_upper(c) == CH_N) begin
                  if (lex_count < LEN_CAP) lex_count = lex_count + 8'd1;
                  r.st = ST_OK;
               end else begin
                  r.st = ST_BAD;
               end
               done = 1;
            end
         endcase
         if (!done) begin
            if (lex_count < LEN_CAP) lex_count = lex_count + 8'd1;
            lex_phase = nx;
         end
      end
      r.len = lex_count;
      if (done) lex_phase = PH_IDLE;
      return done;
   endfunction

   task automatic send_word(input item_type w);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w.ch;
      req_tuser  <= {w.at_end, w.start_req};
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic void put_char(input logic [7:0] c, input logic ends);
      item_type w;
      w.ch = c;
      w.start_req = (field_words.size() == 0);
      w.at_end = ends;
      field_words.push_back(w);
   endfunction

   function automatic logic [7:0] rand_digit();
      return CH_ZERO + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] rand_case(input logic [7:0] c);
      return $urandom_range(0, 1) ? c - CASE_OFS : c;
   endfunction

   // one field of random shape: mostly well formed, some broken, some noise
   function automatic void build_field();
      int         form;
      int         n;
      int         pos;
      logic [7:0] sep [4];
      sep = '{" ", ",", ";", 8'h0A};
      field_words.delete();
      if ($urandom_range(0, 99) < 8) begin
         n = $urandom_range(1, 6);
         repeat (n) begin
            item_type w;
            w.ch = 8'($urandom_range(0, 255));
            w.start_req = ($urandom_range(0, 3) == 0);
            w.at_end = ($urandom_range(0, 5) == 0);
            field_words.push_back(w);
         end
         return;
      end
      if ($urandom_range(0, 1)) put_char(CH_MINUS, 1'b0);
      form = $urandom_range(0, 5);
      if (!long_done && live_words > 200) begin
         // one run past the length cap
         long_done = 1;
         repeat (300) put_char(rand_digit(), 1'b0);
         put_char(8'($urandom_range(0, 255)), 1'b1);
         return;
      end
      if (form == 5) begin
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 3;
         put_char(rand_case(CH_N), 1'b0);
         if (n > 1) put_char(rand_case(CH_A), 1'b0);
         if (n > 2) put_char(rand_case(CH_N), 1'b0);
      end else begin
         if (form == 4) begin
            put_char(CH_POINT, 1'b0);
            repeat ($urandom_range(0, 3)) put_char(rand_digit(), 1'b0);
         end else begin
            repeat ($urandom_range(1, 4)) put_char(rand_digit(), 1'b0);
            if ($urandom_range(0, 1)) begin
               put_char(CH_POINT, 1'b0);
               repeat ($urandom_range(0, 3)) put_char(rand_digit(), 1'b0);
            end
         end
         if ($urandom_range(0, 4) < 2) begin
            put_char(rand_case(CH_E), 1'b0);
            case ($urandom_range(0, 2))
               0: put_char(CH_PLUS, 1'b0);
               1: put_char(CH_MINUS, 1'b0);
               default: ;
            endcase
            repeat ($urandom_range(0, 3)) put_char(rand_digit(), 1'b0);
         end
      end
      if ($urandom_range(0, 99) < 15) begin
         pos = $urandom_range(0, field_words.size() - 1);
         field_words[pos].ch = 8'($urandom_range(0, 255));
      end
      case ($urandom_range(0, 3))
         0: put_char(8'($urandom_range(0, 255)), 1'b1);
         1: put_char(8'($urandom_range(0, 255)), 1'b0);
         2: put_char(sep[$urandom_range(0, 3)], 1'b0);
         default: ;  // next field restarts this one
      endcase
   endfunction

   always @(posedge clock) begin : rsp_check
      field_result_type want;
      status_type       got_st;
      logic [7:0]       got_len;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_st  = status_type'(rsp_tdata[1:0]);
         got_len = rsp_tdata[9:2];
         if (pending_results.size() == 0) begin
            $error("unexpected result word: status %0d length %0d", got_st, got_len);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (got_st != want.st) begin
               $error("status: expected %0d, actual %0d", want.st, got_st);
               fail_count++;
            end
            if (got_len != want.len) begin
               $error("length: expected %0d, actual %0d", want.len, got_len);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // result side: random waits, no-wait stretches, and one long hold-off
   initial begin : rsp_side
      int wait_n;
      int taken;
      bit held;
      bit burst;
      taken = 0;
      held = 0;
      burst = 0;
      while (reset) @(posedge clock);
      forever begin
         if (!held && taken == 30) begin
            held = 1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            wait_n = burst ? 0 : $urandom_range(0, 18);
            if (wait_n > 0) begin
               rsp_tready <= 1'b0;
               repeat (wait_n) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
         if (taken % 16 == 0) burst = ($urandom_range(0, 2) == 0);
      end
   end

   initial begin : req_side
      item_type         w;
      field_result_type r;
      bit               got;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         w.ch = dir_rows[i].ch;
         w.start_req = dir_rows[i].opens;
         w.at_end = dir_rows[i].ends;
         send_burst = (i >= 13 && i < 19);
         send_word(w);
         got = lex_word(w, r);
         if (dir_rows[i].fixed) begin
            if (dir_rows[i].rsp_due) pending_results.push_back('{dir_rows[i].st, dir_rows[i].len});
         end else if (got) begin
            pending_results.push_back(r);
         end
      end

      while (live_words < RAND_WORDS) begin
         build_field();
         send_burst = ($urandom_range(0, 3) == 0);
         foreach (field_words[k]) begin
            w = field_words[k];
            send_word(w);
            if (w.start_req || lex_phase != PH_IDLE) live_words++;
            if (lex_word(w, r)) pending_results.push_back(r);
         end
      end
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
